// ===== rtl/core/md5_pkg.sv =====
// Package with MD5 constants, round tables and helper functions.
package md5_pkg;

	localparam int WordW = 32;
	localparam int BlockDepth = 16;
	localparam int IdxW = 4;
	localparam int RoundW = 6;

	localparam logic [WordW-1:0] InitA = 32'h67452301;
	localparam logic [WordW-1:0] InitB = 32'hEFCDAB89;
	localparam logic [WordW-1:0] InitC = 32'h98BADCFE;
	localparam logic [WordW-1:0] InitD = 32'h10325476;
	localparam logic [WordW-1:0] PadByte = 32'h00000080;

	typedef logic [WordW-1:0] word_t;

	function automatic word_t round_k(input logic [RoundW-1:0] r);
		word_t k;
		begin
			case (r)
				6'd0: k = 32'hD76AA478; 6'd1: k = 32'hE8C7B756;
				6'd2: k = 32'h242070DB; 6'd3: k = 32'hC1BDCEEE;
				6'd4: k = 32'hF57C0FAF; 6'd5: k = 32'h4787C62A;
				6'd6: k = 32'hA8304613; 6'd7: k = 32'hFD469501;
				6'd8: k = 32'h698098D8; 6'd9: k = 32'h8B44F7AF;
				6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
				6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
				6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
				6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
				6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
				6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
				6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
				6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
				6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
				6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
				6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
				6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
				6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
				6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
				6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
				6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
				6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
				6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
				6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
				6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
				6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
				6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
				6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
				6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
				6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
				6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
				6'd62: k = 32'h2AD7D2BB; default: k = 32'hEB86D391;
			endcase
			return k;
		end
	endfunction

	function automatic logic [4:0] round_s(input logic [RoundW-1:0] r);
		logic [4:0] s;
		begin
			case ({r[5:4], r[1:0]})
				4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
				4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
				4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
				4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
			endcase
			return s;
		end
	endfunction

	// message word index used by a round
	function automatic logic [IdxW-1:0] round_g(input logic [RoundW-1:0] r);
		logic [IdxW-1:0] ri;
		logic [IdxW-1:0] g;
		begin
			ri = r[3:0];
			case (r[5:4])
				2'd0: g = ri;
				2'd1: g = IdxW'(5 * ri + 1);
				2'd2: g = IdxW'(3 * ri + 5);
				default: g = IdxW'(7 * ri);
			endcase
			return g;
		end
	endfunction

	function automatic word_t rotl(input word_t v, input logic [4:0] n);
		logic [2*WordW-1:0] dbl;
		begin
			dbl = {v, v} << n;
			return dbl[2*WordW-1:WordW];
		end
	endfunction

endpackage

// ===== rtl/core/md5_message_digest_top.sv =====
// MD5 message digest core: word buffer memory, round engine and padding sequencer.
//
//  channel | dir | handshake        | tdata / tuser
//  s_axis  | in  | s_axis_tvalid/rdy | data_word[31:0]; tuser bytes_valid; tlast last_word
//  m_axis  | out | m_axis_tvalid/rdy | digest_word[31:0]; tuser digest_index; tlast digest_last
//
// A word that does not fill the buffer is written to the buffer memory. A word
// that fills it starts a block: 64 rounds, one per cycle, each reading its
// message word from the buffer memory one round ahead, then the chaining add.
// No input word is accepted until the block is done. A last word adds padding
// writes (one per word) and one or two blocks, then four digest transfers.
// Reset is asynchronous and returns the chaining values to the MD5 initial
// vector; the buffer needs no clearing. Output stalls hold the block.
module md5_message_digest_top
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] data_word
	input  logic [2:0]  s_axis_tuser,   // [2:0] bytes_valid
	input  logic        s_axis_tlast,   // last_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [1:0]  m_axis_tuser,   // [1:0] digest_index
	output logic        m_axis_tlast    // digest_last
);

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StPad   = 3'd1;
	localparam logic [2:0] StRound = 3'd2;
	localparam logic [2:0] StAdd   = 3'd3;
	localparam logic [2:0] StOut   = 3'd4;

	logic [2:0] state_q;
	word_t mem [BlockDepth];
	word_t rd_data_q;
	logic mem_we;
	logic [IdxW-1:0] mem_wa;
	word_t mem_wd;
	logic [IdxW-1:0] mem_ra;

	word_t ch_q [4];
	word_t a_q, b_q, c_q, d_q;
	logic [60:0] byte_cnt_q;
	logic [IdxW-1:0] fill_q;
	logic [RoundW-1:0] rnd_q;
	logic pad_q;          // padding in progress after the last word
	logic [1:0] len_ph_q; // 1 pad byte pending, 2 zero fill, 3 length low written
	logic [1:0] out_idx_q;

	logic acc;
	logic [2:0] nb;
	word_t tail_word;
	logic [63:0] bits;
	logic [60:0] cnt_next;
	word_t f_val, f_sum;

	assign s_axis_tready = (state_q == StIdle);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign nb = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;
	assign bits = {byte_cnt_q, 3'b000};

	always_comb begin
		case (nb)
			3'd0: tail_word = PadByte;
			3'd1: tail_word = {16'h0, 8'h80, s_axis_tdata[7:0]};
			3'd2: tail_word = {8'h0, 8'h80, s_axis_tdata[15:0]};
			3'd3: tail_word = {8'h80, s_axis_tdata[23:0]};
			default: tail_word = s_axis_tdata;
		endcase
		cnt_next = byte_cnt_q + (s_axis_tlast ? 61'(nb) : 61'd4);
	end

	// write side: input words or padding words
	always_comb begin
		mem_we = 1'b0;
		mem_wa = fill_q;
		mem_wd = '0;
		if (acc) begin
			mem_we = 1'b1;
			mem_wd = s_axis_tlast ? tail_word : s_axis_tdata;
		end else if (state_q == StPad) begin
			mem_we = 1'b1;
			if (len_ph_q == 2'd1) mem_wd = PadByte;
			else if (len_ph_q == 2'd3) mem_wd = bits[63:32];
			else if (fill_q == 4'd14) mem_wd = bits[31:0];
		end
	end

	// read one round ahead
	always_comb begin
		mem_ra = round_g(rnd_q + 6'd1);
		if (state_q != StRound) mem_ra = round_g(6'd0);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_data_q <= mem[mem_ra];
	end

	always_comb begin
		unique case (rnd_q[5:4])
			2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1: f_val = (d_q & b_q) | (~d_q & c_q);
			2'd2: f_val = b_q ^ c_q ^ d_q;
			default: f_val = c_q ^ (b_q | ~d_q);
		endcase
		f_sum = f_val + a_q + round_k(rnd_q) + rd_data_q;
	end

	// len_ph_q: 1 = full word with pad byte pending, 2 = zero fill,
	// 3 = length low word written, high word next (final block)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			ch_q[0] <= InitA; ch_q[1] <= InitB; ch_q[2] <= InitC; ch_q[3] <= InitD;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
			byte_cnt_q <= '0;
			fill_q <= '0;
			rnd_q <= '0;
			pad_q <= 1'b0;
			len_ph_q <= '0;
			out_idx_q <= '0;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (acc) begin
						byte_cnt_q <= cnt_next;
						fill_q <= fill_q + 4'd1;
						if (s_axis_tlast) begin
							pad_q <= 1'b1;
							len_ph_q <= (nb == 3'd4) ? 2'd1 : 2'd2;
						end
						if (fill_q == 4'd15) begin
							state_q <= StRound;
							rnd_q <= '0;
							a_q <= ch_q[0]; b_q <= ch_q[1]; c_q <= ch_q[2]; d_q <= ch_q[3];
						end else if (s_axis_tlast) begin
							state_q <= StPad;
						end
					end
				end
				StPad: begin
					fill_q <= fill_q + 4'd1;
					if (len_ph_q == 2'd1) len_ph_q <= 2'd2;
					else if (len_ph_q == 2'd2 && fill_q == 4'd14) len_ph_q <= 2'd3;
					if (fill_q == 4'd15) begin
						state_q <= StRound;
						rnd_q <= '0;
						a_q <= ch_q[0]; b_q <= ch_q[1]; c_q <= ch_q[2]; d_q <= ch_q[3];
					end
				end
				StRound: begin
					a_q <= d_q;
					d_q <= c_q;
					c_q <= b_q;
					b_q <= b_q + rotl(f_sum, round_s(rnd_q));
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= StAdd;
				end
				StAdd: begin
					ch_q[0] <= ch_q[0] + a_q; ch_q[1] <= ch_q[1] + b_q;
					ch_q[2] <= ch_q[2] + c_q; ch_q[3] <= ch_q[3] + d_q;
					rnd_q <= '0;
					if (!pad_q) begin
						state_q <= StIdle;
					end else if (len_ph_q == 2'd3) begin
						// block ending with the length words was the final one
						state_q <= StOut;
						out_idx_q <= '0;
					end else begin
						state_q <= StPad;
					end
				end
				StOut: begin
					if (m_axis_tready) begin
						out_idx_q <= out_idx_q + 2'd1;
						if (out_idx_q == 2'd3) begin
							state_q <= StIdle;
							ch_q[0] <= InitA; ch_q[1] <= InitB;
							ch_q[2] <= InitC; ch_q[3] <= InitD;
							byte_cnt_q <= '0;
							fill_q <= '0;
							pad_q <= 1'b0;
							len_ph_q <= '0;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assign m_axis_tvalid = (state_q == StOut);
	assign m_axis_tdata = ch_q[out_idx_q];
	assign m_axis_tuser = out_idx_q;
	assign m_axis_tlast = (out_idx_q == 2'd3);

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StRound) |-> !s_axis_tready) else $error("input taken mid block");
	a_round_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StRound && rnd_q != 6'd63) |=> (state_q == StRound))
		else $error("round sequence broken");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(out_idx_q)))
		else $error("digest dropped");

endmodule
